// ===== sv/touch_packet_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// touch_packet_decoder_macros
// Assertion macros shared by the touch packet decoder.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PACKET_DECODER_MACROS_SVH
`define TOUCH_PACKET_DECODER_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define TPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch_packet_decoder: same-cycle check failed");

// Check that a condition implies another one in the following cycle.
`define TPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch_packet_decoder: next-cycle check failed");

`endif

// ===== sv/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpd_pkg
// Types, constants and codes shared by the touch packet decoder modules.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int MAX_FINGERS = 2;
    localparam int MAX_PAYLOAD = 66;
    localparam int REC_LEN     = 6;
    localparam int REC_STORED  = REC_LEN - 1;

    localparam int FIDX_W   = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
    localparam int LEN_W    = 7;
    localparam int SLOT_W   = $clog2(REC_LEN);
    localparam int COORD_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int ID_W     = 4;
    localparam int TDATA_W  = 48;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(REC_LEN - 1);
    localparam logic [FIDX_W-1:0] IDX_LAST  = FIDX_W'(MAX_FINGERS - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_PAYLOAD);

    // Header and record byte 0 layout
    localparam int ESD_BIT    = 7;
    localparam int ACTION_BIT = 7;

    typedef enum logic [1:0] {
        TYPE_KEY    = 2'd0,
        TYPE_SCREEN = 2'd1,
        TYPE_RSVD2  = 2'd2,
        TYPE_RSVD3  = 2'd3
    } rec_type_t;

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_RELEASING = 2'd1,
        ST_DOWN      = 2'd2
    } finger_st_t;

    typedef enum logic [1:0] {
        KIND_CONTACT = 2'd0,
        KIND_SYNC    = 2'd1,
        KIND_RESET   = 2'd2
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic              accept;
        logic              start_walk;
        logic              load_contact;
        logic              load_sync;
        logic              load_esd;
        logic              retire;
        logic              sync_last;
        logic [FIDX_W-1:0] idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic esd;
        logic ends_packet;
        logic active;
        logic released;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/tpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpd_ctrl
// Controller: input handshake and the end-of-packet report walk.
// ----------------------------------------------------------------------------
module tpd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tpd_pkg::sts_t sts,
    output tpd_pkg::cmd_t cmd
);
    import tpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ESD  = 4'b0010,
        S_WALK = 4'b0100,
        S_SYNC = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [FIDX_W-1:0] idx_reg, idx_next;
    logic              pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (sts.esd)
                    begin
                        state_next = S_ESD;
                    end
                    else if (sts.ends_packet)
                    begin
                        cmd.start_walk = 1'b1;
                        idx_next       = '0;
                        pass_next      = 1'b0;
                        state_next     = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // skip idle fingers, wait for the output slot otherwise
                if (!sts.active || sts.out_free)
                begin
                    cmd.load_contact = sts.active;
                    cmd.retire       = sts.active && !pass_reg;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_SYNC;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_SYNC:
            begin
                if (sts.out_free)
                begin
                    cmd.load_sync = 1'b1;
                    cmd.sync_last = pass_reg || !sts.released;
                    if (!pass_reg && sts.released)
                    begin
                        pass_next  = 1'b1;
                        idx_next   = '0;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ESD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_esd = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/tpd_dp.sv =====
// ----------------------------------------------------------------------------
// tpd_dp
// Datapath: packet framing, record decode, finger table and output register.
// ----------------------------------------------------------------------------
module tpd_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tpd_pkg::BYTE_W-1:0]        in_byte,
    input  logic                              in_start,
    input  tpd_pkg::cmd_t                     cmd,
    output tpd_pkg::sts_t                     sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tpd_pkg::TDATA_W-1:0]       out_data,
    output logic [1:0]                        out_kind,
    output logic                              out_last
);
    import tpd_pkg::*;

    finger_st_t         status_reg   [MAX_FINGERS];
    logic [COORD_W-1:0] fx_reg       [MAX_FINGERS];
    logic [COORD_W-1:0] fy_reg       [MAX_FINGERS];
    logic [BYTE_W-1:0]  fwidth_reg   [MAX_FINGERS];
    logic [BYTE_W-1:0]  fstrength_reg[MAX_FINGERS];
    logic [BYTE_W-1:0]  rec_reg      [REC_STORED];

    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   pos_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               in_pkt_reg;
    logic               released_reg;

    logic               ov_reg;
    kind_t              okind_reg;
    logic               ofinger_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg;
    logic [BYTE_W-1:0]  omajor_reg, owidth_reg;
    logic               olast_reg;

    logic [LEN_W-1:0]   hdr_len;
    logic [LEN_W-1:0]   pos_inc;
    logic               is_esd;
    logic               hdr_ok;
    logic               pay_byte;
    logic               pay_end;
    logic               apply;
    logic [ID_W-1:0]    rec_id;
    logic               rec_used;
    logic               out_free;

    // Header decode with length clamp
    assign hdr_len  = (in_byte[LEN_W-1:0] > LEN_MAX) ? LEN_MAX : in_byte[LEN_W-1:0];
    assign is_esd   = in_start && in_byte[ESD_BIT];
    assign hdr_ok   = in_start && !in_byte[ESD_BIT];
    assign pay_byte = !in_start && in_pkt_reg;
    assign pos_inc  = pos_reg + 1'b1;
    assign pay_end  = pay_byte && (pos_inc >= len_reg);
    assign apply    = cmd.accept && pay_byte && (slot_reg == SLOT_LAST);

    assign rec_id   = rec_reg[0][ID_W-1:0];
    assign rec_used = (rec_reg[0][6:5] == TYPE_SCREEN) && (rec_id != '0)
                      && (rec_id <= ID_W'(MAX_FINGERS));

    assign out_free = !ov_reg || out_ready;

    assign sts.esd         = is_esd;
    assign sts.ends_packet = (hdr_ok && (hdr_len == '0)) || pay_end;
    assign sts.active      = (status_reg[cmd.idx] != ST_IDLE);
    assign sts.released    = released_reg;
    assign sts.out_free    = out_free;

    // Packet framing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            pos_reg    <= '0;
            slot_reg   <= '0;
            in_pkt_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (is_esd)
            begin
                in_pkt_reg <= 1'b0;
            end
            else if (hdr_ok)
            begin
                len_reg    <= hdr_len;
                pos_reg    <= '0;
                slot_reg   <= '0;
                in_pkt_reg <= (hdr_len != '0);
            end
            else if (pay_byte)
            begin
                pos_reg    <= pos_inc;
                slot_reg   <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                in_pkt_reg <= !pay_end;
            end
        end
    end

    // Record byte buffer
    always_ff @(posedge clk)
    begin
        if (cmd.accept && pay_byte && (slot_reg != SLOT_LAST))
        begin
            rec_reg[slot_reg[SLOT_W-1:0]] <= in_byte;
        end
    end

    // Finger table: record apply on accept, retire during the first pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FINGERS; i++)
            begin
                status_reg[i]    <= ST_IDLE;
                fx_reg[i]        <= '0;
                fy_reg[i]        <= '0;
                fwidth_reg[i]    <= '0;
                fstrength_reg[i] <= '0;
            end
            released_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_walk)
            begin
                released_reg <= 1'b0;
            end
            if (cmd.retire && (status_reg[cmd.idx] == ST_RELEASING))
            begin
                status_reg[cmd.idx] <= ST_IDLE;
                released_reg        <= 1'b1;
            end
            for (int i = 0; i < MAX_FINGERS; i++)
            begin
                if (apply && rec_used && (rec_id == ID_W'(i + 1)))
                begin
                    if (!rec_reg[0][ACTION_BIT])
                    begin
                        status_reg[i]    <= ST_RELEASING;
                        fstrength_reg[i] <= '0;
                        fwidth_reg[i]    <= '0;
                    end
                    else
                    begin
                        fx_reg[i]        <= {rec_reg[1][3:0], rec_reg[2]};
                        fy_reg[i]        <= {rec_reg[1][7:4], rec_reg[3]};
                        fwidth_reg[i]    <= rec_reg[4];
                        fstrength_reg[i] <= in_byte;
                        status_reg[i]    <= ST_DOWN;
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.load_contact || cmd.load_sync || cmd.load_esd)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_contact)
        begin
            okind_reg   <= KIND_CONTACT;
            ofinger_reg <= cmd.idx[0];
            ox_reg      <= fx_reg[cmd.idx];
            oy_reg      <= fy_reg[cmd.idx];
            omajor_reg  <= fstrength_reg[cmd.idx];
            owidth_reg  <= fwidth_reg[cmd.idx];
            olast_reg   <= 1'b0;
        end
        else if (cmd.load_sync || cmd.load_esd)
        begin
            okind_reg   <= cmd.load_esd ? KIND_RESET : KIND_SYNC;
            ofinger_reg <= 1'b0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            omajor_reg  <= '0;
            owidth_reg  <= '0;
            olast_reg   <= cmd.load_esd || cmd.sync_last;
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;
    assign out_data  = {7'b0, owidth_reg, omajor_reg, oy_reg, ox_reg, ofinger_reg};

endmodule

// ===== sv/touch_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// touch_packet_decoder
// Byte-serial decoder for touch controller event packets.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one packet byte per item on s_tdata, s_tuser high on the
//   header byte. A header with bit 7 set raises one reset request item.
//   Otherwise the payload (length clamped to 66) is split into 6-byte
//   records that update a two-entry finger table.
//   Output stream: after the last payload byte the block sends one contact
//   item per active finger, then a sync; if a finger was released, a second
//   walk follows with the fingers still down and another sync. m_tlast
//   marks the final item caused by one input byte.
// Flow control:
//   A payload byte that does not close the packet is taken while the
//   sequencer stays idle. A byte that closes it holds the input through
//   the report walk (one step per finger slot in the report sequencer,
//   one for the sync) and through the second walk if one follows; a reset
//   request holds it until its item is loaded. Results are registered:
//   the output register drives the output stream directly.
// Reset clears the finger table, framing state and output valid.
// A stalled m_tready holds the walk; the input stays open while the last
//   result of a byte waits in the output register.
// ----------------------------------------------------------------------------
`include "touch_packet_decoder_macros.svh"

module touch_packet_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] packet_byte
    input  logic                                s_tuser,  // [0] packet_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] finger, [12:1] pos_x, [24:13] pos_y, [32:25] touch_major,
    // [40:33] contact_width, [47:41] zero
    output logic [tpd_pkg::TDATA_W-1:0]         m_tdata,
    output logic [1:0]                          m_tuser,  // [1:0] kind
    output logic                                m_tlast
);
    import tpd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: handshake and report walk
    tpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Framing, finger table and output register
    tpd_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

    // A reset request is always the only item of its byte
    `TPD_ASSERT_IMPLY(a_esd_last, clk, rst_n, m_tvalid && (m_tuser == KIND_RESET), m_tlast)
    // A contact report is never the closing item of a walk
    `TPD_ASSERT_IMPLY(a_contact_not_last, clk, rst_n, m_tvalid && (m_tuser == KIND_CONTACT), !m_tlast)
    // Sync and reset items carry an all-zero payload
    `TPD_ASSERT_IMPLY(a_sync_zero, clk, rst_n, m_tvalid && (m_tuser != KIND_CONTACT), m_tdata == '0)
    // A closing byte stops the input until its walk is done
    `TPD_ASSERT_NEXT(a_walk_blocks, clk, rst_n, cmd.start_walk, !s_tready)

endmodule
